// File: hw/rtl/pat_pkg.sv
// Shared field widths, request codes and word layouts for the paged allocator.
package pat_pkg;

  localparam int ADDR_W = 20;
  localparam int SIZE_W = 21;
  localparam int PID_W  = 4;
  localparam int BYTE_W = 8;
  localparam int MODE_W = 2;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd3;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] base;
    logic [BYTE_W-1:0] rbyte;
  } result_t;

endpackage

// File: hw/rtl/pat_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module pat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/paged_allocator_with_translation_unit.sv
// Top level: paged memory manager with per-process page translation and byte RAM.
//
//   channel  | signals                          | payload
//   ---------+----------------------------------+----------------------------------------
//   request  | s_axis_tvalid/tready/tdata/tuser | tuser: mode; tdata: pid,size,addr,byte
//   result   | m_axis_tvalid/tready/tdata/tuser | tuser: status; tdata: base, read_byte
//   config   | cfg_we, cfg_wdata                | start_break, reloads every break
//
// Read and write look up the page map, then access the byte RAM; a bad pid goes straight
// to the result. Allocate scans frames up to the last one claimed, and skips the scan on
// failure or size zero. Free walks the frame chain, then drops the break past unmapped
// pages until a mapped page stops the drop; it ends at once when the address is unmapped.
// After reset a clearing pass zeroes all memories; no word is taken during it.
// A finished result waits in the output register while the next word is taken.
module paged_allocator_with_translation_unit
  import pat_pkg::*;
#(
  parameter int OFFSET_BITS  = 10,
  parameter int PAGE_BITS    = 5,
  parameter int SEGMENT_BITS = 5,
  parameter int FRAMES       = 256,
  parameter int PROCESSES    = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] pid, [24:4] size, [44:25] address, [52:45] write_byte, [55:53] zero
  input  logic [55:0] s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [19:0] base_address, [27:20] read_byte, [31:28] zero
  output logic [31:0] m_axis_tdata,
  // [0] status
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata
);

  localparam int FRAME_W = $clog2(FRAMES);
  localparam int PROC_W  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int VPAGE_W = SEGMENT_BITS + PAGE_BITS;
  localparam int VA_W    = VPAGE_W + OFFSET_BITS;
  localparam int SUM_W   = ((VA_W > 22) ? VA_W : 22) + 1;
  localparam int STEP_W  = $clog2(FRAMES + 1);
  localparam int WS_W    = ((VPAGE_W > STEP_W) ? VPAGE_W : STEP_W) + 1;
  localparam int FE_W    = PID_W + 1 + FRAME_W;
  localparam int ME_W    = 1 + FRAME_W;
  localparam int MA_W    = PROC_W + VPAGE_W;
  localparam int RA_W    = FRAME_W + OFFSET_BITS;
  localparam int CLR_W   = (RA_W > MA_W) ? RA_W : MA_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACALC = 4'd1;
  localparam logic [3:0] S_ACHK  = 4'd2;
  localparam logic [3:0] S_AREAD = 4'd3;
  localparam logic [3:0] S_ATEST = 4'd4;
  localparam logic [3:0] S_AFIN  = 4'd5;
  localparam logic [3:0] S_FMAP  = 4'd6;
  localparam logic [3:0] S_FLOOK = 4'd7;
  localparam logic [3:0] S_FRD   = 4'd8;
  localparam logic [3:0] S_FCHK  = 4'd9;
  localparam logic [3:0] S_SRD   = 4'd10;
  localparam logic [3:0] S_SCHK  = 4'd11;
  localparam logic [3:0] S_RMAP  = 4'd12;
  localparam logic [3:0] S_RLOOK = 4'd13;
  localparam logic [3:0] S_RRAM  = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [3:0]          state;
  logic                clearing;
  logic [CLR_W-1:0]    clr_cnt;
  logic [ADDR_W-1:0]   start_break;
  logic [SUM_W-1:0]    brk [PROCESSES];
  logic [FRAME_W:0]    free_count;
  logic [MODE_W-1:0]   r_mode;
  logic [PID_W-1:0]    r_pid;
  logic [PROC_W-1:0]   r_proc;
  logic [SIZE_W-1:0]   r_size;
  logic [VPAGE_W-1:0]  r_vpage;
  logic [OFFSET_BITS-1:0] r_off;
  logic [BYTE_W-1:0]   r_wbyte;
  logic [SUM_W-1:0]    pages;
  logic [SUM_W-1:0]    brk_w;
  logic [SUM_W-1:0]    brk_end;
  logic [FRAME_W:0]    k;
  logic [FRAME_W-1:0]  scan;
  logic                have_last;
  logic [FRAME_W-1:0]  last;
  logic [FRAME_W-1:0]  cur_f;
  logic [STEP_W-1:0]   steps;
  result_t             res;

  logic [PID_W-1:0]    s_pid;
  logic [SIZE_W-1:0]   s_size;
  logic [ADDR_W-1:0]   s_addr;
  logic [BYTE_W-1:0]   s_wbyte;
  logic                accept;
  logic [SUM_W-1:0]    brk_cur;
  logic [SUM_W-1:0]    vspan;
  logic [SUM_W-1:0]    alloc_end;
  logic [SUM_W-1:0]    shrink_floor;
  logic [WS_W-1:0]     walk_sum;
  logic                walk_in_range;
  logic [VPAGE_W-1:0]  alloc_vp;
  logic [VPAGE_W-1:0]  below_vp;

  logic                fr_we;
  logic [FRAME_W-1:0]  fr_waddr, fr_raddr;
  logic [FE_W-1:0]     fr_wdata, fr_rdata;
  logic                mp_we;
  logic [MA_W-1:0]     mp_waddr, mp_raddr;
  logic [ME_W-1:0]     mp_wdata, mp_rdata;
  logic                rb_we;
  logic [RA_W-1:0]     rb_waddr, rb_raddr;
  logic [BYTE_W-1:0]   rb_wdata, rb_rdata;

  logic [PID_W-1:0]    fr_owner;
  logic                fr_end;
  logic [FRAME_W-1:0]  fr_next;
  logic                mp_valid;
  logic [FRAME_W-1:0]  mp_frame;

  assign s_pid   = s_axis_tdata[3:0];
  assign s_size  = s_axis_tdata[24:4];
  assign s_addr  = s_axis_tdata[44:25];
  assign s_wbyte = s_axis_tdata[52:45];

  assign s_axis_tready = (state == S_IDLE) && !clearing;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign fr_owner = fr_rdata[FE_W-1 -: PID_W];
  assign fr_end   = fr_rdata[FRAME_W];
  assign fr_next  = fr_rdata[FRAME_W-1:0];
  assign mp_valid = mp_rdata[FRAME_W];
  assign mp_frame = mp_rdata[FRAME_W-1:0];

  assign brk_cur       = brk[r_proc];
  assign vspan         = SUM_W'(1) << VA_W;
  assign alloc_end     = brk_w + (pages << OFFSET_BITS);
  assign shrink_floor  = SUM_W'(start_break) + (SUM_W'(1) << OFFSET_BITS);
  assign walk_sum      = WS_W'(r_vpage) + WS_W'(steps);
  assign walk_in_range = walk_sum < (WS_W'(1) << VPAGE_W);
  assign alloc_vp      = VPAGE_W'((brk_w >> OFFSET_BITS) + SUM_W'(k));
  assign below_vp      = VPAGE_W'((brk_w >> OFFSET_BITS) - SUM_W'(1));

  // memory ports; the clearing pass owns every write port
  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = last;
    fr_wdata = '0;
    fr_raddr = (state == S_AREAD) ? scan : cur_f;
    mp_we    = 1'b0;
    mp_waddr = {r_proc, alloc_vp};
    mp_wdata = {1'b1, scan};
    mp_raddr = {r_proc, r_vpage};
    rb_we    = 1'b0;
    rb_waddr = {mp_frame, r_off};
    rb_wdata = r_wbyte;
    rb_raddr = {mp_frame, r_off};
    case (state)
      S_FRD:   mp_raddr = {r_proc, walk_sum[VPAGE_W-1:0]};
      S_SRD:   mp_raddr = {r_proc, below_vp};
      default: mp_raddr = {r_proc, r_vpage};
    endcase
    if (clearing) begin
      fr_we    = (clr_cnt >> FRAME_W) == '0;
      fr_waddr = clr_cnt[FRAME_W-1:0];
      mp_we    = (clr_cnt >> MA_W) == '0;
      mp_waddr = clr_cnt[MA_W-1:0];
      mp_wdata = '0;
      rb_we    = (clr_cnt >> RA_W) == '0;
      rb_waddr = clr_cnt[RA_W-1:0];
      rb_wdata = '0;
    end else begin
      case (state)
        S_ATEST: begin
          if (fr_owner == '0) begin
            fr_we    = have_last;
            fr_wdata = {r_pid, 1'b0, scan};
            mp_we    = 1'b1;
          end
        end
        S_AFIN: begin
          fr_we    = 1'b1;
          fr_wdata = {r_pid, 1'b1, {FRAME_W{1'b0}}};
        end
        S_FCHK: begin
          if (fr_owner == r_pid) begin
            fr_we    = 1'b1;
            fr_waddr = cur_f;
            mp_we    = walk_in_range && mp_valid && (mp_frame == cur_f);
            mp_waddr = {r_proc, walk_sum[VPAGE_W-1:0]};
            mp_wdata = '0;
          end
        end
        S_RLOOK: rb_we = mp_valid && (r_mode == MODE_WRITE);
        default: ;
      endcase
    end
  end

  pat_ram #(.WIDTH(FE_W), .DEPTH(2 ** FRAME_W)) u_frame_ram (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
    .raddr(fr_raddr), .rdata(fr_rdata)
  );

  pat_ram #(.WIDTH(ME_W), .DEPTH(2 ** MA_W)) u_map_ram (
    .clk(clk), .we(mp_we), .waddr(mp_waddr), .wdata(mp_wdata),
    .raddr(mp_raddr), .rdata(mp_rdata)
  );

  pat_ram #(.WIDTH(BYTE_W), .DEPTH(2 ** RA_W)) u_byte_ram (
    .clk(clk), .we(rb_we), .waddr(rb_waddr), .wdata(rb_wdata),
    .raddr(rb_raddr), .rdata(rb_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      clearing      <= 1'b1;
      clr_cnt       <= '0;
      start_break   <= 20'd1024;
      free_count    <= (FRAME_W+1)'(FRAMES);
      m_axis_tvalid <= 1'b0;
      for (int p = 0; p < PROCESSES; p++) begin
        brk[p] <= SUM_W'(20'd1024);
      end
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (&clr_cnt) begin
          clearing <= 1'b0;
        end
      end
      if (cfg_we) begin
        start_break <= cfg_wdata;
        for (int p = 0; p < PROCESSES; p++) begin
          brk[p] <= SUM_W'(cfg_wdata);
        end
      end
      // the done state reloads the output word itself
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            r_mode  <= s_axis_tuser;
            r_pid   <= s_pid;
            r_proc  <= PROC_W'(s_pid - 4'd1);
            r_size  <= s_size;
            r_vpage <= VPAGE_W'(s_addr >> OFFSET_BITS);
            r_off   <= s_addr[OFFSET_BITS-1:0];
            r_wbyte <= s_wbyte;
            res     <= '{status: 1'b1, base: '0, rbyte: '0};
            if (s_pid == '0 || 8'(s_pid) > 8'(PROCESSES)) begin
              state <= S_DONE;
            end else begin
              case (s_axis_tuser)
                MODE_ALLOC: state <= S_ACALC;
                MODE_FREE:  state <= S_FMAP;
                default:    state <= S_RMAP;
              endcase
            end
          end
        end
        S_ACALC: begin
          pages <= (SUM_W'(r_size) + SUM_W'((1 << OFFSET_BITS) - 1)) >> OFFSET_BITS;
          brk_w <= brk_cur;
          state <= S_ACHK;
        end
        S_ACHK: begin
          k         <= '0;
          scan      <= '0;
          have_last <= 1'b0;
          brk_end   <= alloc_end;
          if (SUM_W'(free_count) < pages || alloc_end >= vspan) begin
            state <= S_DONE;
          end else if (pages == '0) begin
            res.status <= 1'b0;
            res.base   <= ADDR_W'(brk_w & (vspan - SUM_W'(1)));
            state      <= S_DONE;
          end else begin
            state <= S_AREAD;
          end
        end
        S_AREAD: state <= S_ATEST;
        S_ATEST: begin
          // hold the claimed frame as pending until its successor is known
          if (fr_owner == '0) begin
            last      <= scan;
            have_last <= 1'b1;
            k         <= k + 1'b1;
            if (SUM_W'(k) + SUM_W'(1) == pages) begin
              state <= S_AFIN;
            end else begin
              scan  <= scan + 1'b1;
              state <= S_AREAD;
            end
          end else begin
            scan  <= scan + 1'b1;
            state <= S_AREAD;
          end
        end
        S_AFIN: begin
          brk[r_proc] <= brk_end;
          free_count  <= free_count - pages[FRAME_W:0];
          res.status  <= 1'b0;
          res.base    <= ADDR_W'(brk_w & (vspan - SUM_W'(1)));
          state       <= S_DONE;
        end
        S_FMAP: state <= S_FLOOK;
        S_FLOOK: begin
          cur_f <= mp_frame;
          steps <= '0;
          state <= mp_valid ? S_FRD : S_DONE;
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (fr_owner == r_pid) begin
            free_count <= free_count + 1'b1;
            steps      <= steps + 1'b1;
            cur_f      <= fr_next;
            if (fr_end || (steps + 1'b1) == STEP_W'(FRAMES)) begin
              brk_w <= brk_cur;
              state <= S_SRD;
            end else begin
              state <= S_FRD;
            end
          end else begin
            brk_w <= brk_cur;
            state <= S_SRD;
          end
        end
        S_SRD: begin
          if (brk_w >= shrink_floor) begin
            state <= S_SCHK;
          end else begin
            brk[r_proc] <= brk_w;
            res.status  <= 1'b0;
            state       <= S_DONE;
          end
        end
        S_SCHK: begin
          if (!mp_valid) begin
            brk_w <= brk_w - (SUM_W'(1) << OFFSET_BITS);
            state <= S_SRD;
          end else begin
            brk[r_proc] <= brk_w;
            res.status  <= 1'b0;
            state       <= S_DONE;
          end
        end
        S_RMAP: state <= S_RLOOK;
        S_RLOOK: begin
          if (!mp_valid) begin
            state <= S_DONE;
          end else if (r_mode == MODE_READ) begin
            state <= S_RRAM;
          end else begin
            res.status <= 1'b0;
            state      <= S_DONE;
          end
        end
        S_RRAM: begin
          res.status <= 1'b0;
          res.rbyte  <= rb_rdata;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {4'b0, res.rbyte, res.base};
            m_axis_tuser  <= res.status;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_free_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= (FRAME_W+1)'(FRAMES))
    else $error("free frame count above frame total");

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready)
    else $error("request taken during clearing pass");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted word did not start work");

  a_alloc_end_in_span: assert property (@(posedge clk) disable iff (rst)
    state == S_AFIN |-> brk_end < vspan)
    else $error("allocation break beyond virtual span");

  a_done_gives_result: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && !m_axis_tvalid |=> m_axis_tvalid)
    else $error("finished result not presented");

endmodule

// File: verif/testbench.sv
// Testbench for the paged allocator: predicts every result word and checks it in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pat_pkg::*;

  localparam int PAGE      = 1024;
  localparam int VPAGES    = 1024;
  localparam int VSPAN     = 1 << 20;
  localparam int NFRAMES   = 256;
  localparam int NPROC     = 8;
  localparam int QUIET_MAX = 1000000;
  localparam int PHASE_ITEMS = 150;

  class pager_model;
    bit [3:0]  owner[NFRAMES];
    bit [8:0]  link_next[NFRAMES];
    bit        link_end[NFRAMES];
    bit        map_valid[NPROC][VPAGES];
    bit [8:0]  map_frame[NPROC][VPAGES];
    int        brk[NPROC];
    bit [7:0]  ram[int];
    int        start_brk;
    result_t   pending_results[$];
    int        errors;

    function new();
      load_start(1024);
    endfunction

    function void load_start(int value);
      start_brk = value;
      foreach (brk[p]) brk[p] = value;
    endfunction

    function result_t take_request(bit [1:0] mode, bit [3:0] pid, bit [20:0] size,
                                   bit [19:0] addr, bit [7:0] wbyte);
      result_t r;
      int proc, pages, nfree, k, last, f, vp, steps, v, nx, b, phys;
      bit stop;
      r.status = 1'b1;
      r.base = '0;
      r.rbyte = '0;
      if (pid != 0 && pid <= NPROC) begin
        proc = pid - 1;
        vp = addr >> 10;
        case (mode)
          MODE_ALLOC: begin
            pages = (int'(size) + PAGE - 1) >> 10;
            nfree = 0;
            foreach (owner[i]) if (owner[i] == 0) nfree++;
            b = brk[proc];
            if (nfree >= pages && b + pages * PAGE < VSPAN) begin
              k = 0;
              last = -1;
              for (f = 0; f < NFRAMES && k < pages; f++) begin
                if (owner[f] == 0) begin
                  owner[f] = pid;
                  link_next[f] = 0;
                  link_end[f] = 1'b1;
                  if (last >= 0) begin
                    link_next[last] = f;
                    link_end[last] = 1'b0;
                  end
                  last = f;
                  v = ((b + k * PAGE) >> 10) & (VPAGES - 1);
                  map_valid[proc][v] = 1'b1;
                  map_frame[proc][v] = f;
                  k++;
                end
              end
              brk[proc] = b + pages * PAGE;
              r.status = 1'b0;
              r.base = b[19:0];
            end
          end
          MODE_FREE: begin
            if (map_valid[proc][vp]) begin
              f = map_frame[proc][vp];
              steps = 0;
              stop = 1'b0;
              while (!stop && steps < NFRAMES && owner[f] == pid) begin
                v = vp + steps;
                nx = link_next[f];
                stop = link_end[f];
                owner[f] = 0;
                if (v < VPAGES && map_valid[proc][v] && map_frame[proc][v] == f)
                  map_valid[proc][v] = 1'b0;
                steps++;
                f = nx;
              end
              // drop the break past unmapped top pages, never below start
              b = brk[proc];
              while (b >= start_brk + PAGE && !map_valid[proc][((b - PAGE) >> 10) & (VPAGES - 1)])
                b -= PAGE;
              brk[proc] = b;
              r.status = 1'b0;
            end
          end
          default: begin
            if (map_valid[proc][vp]) begin
              phys = (int'(map_frame[proc][vp]) << 10) | (addr & (PAGE - 1));
              if (mode == MODE_READ) r.rbyte = ram.exists(phys) ? ram[phys] : 8'd0;
              else ram[phys] = wbyte;
              r.status = 1'b0;
            end
          end
        endcase
      end
      pending_results.push_back(r);
      return r;
    endfunction

    function void check_result(logic status, logic [19:0] base, logic [7:0] rbyte);
      result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word status=%0d base=%h byte=%h",
                 $time, status, base, rbyte);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, status);
        errors++;
      end
      if (base !== e.base) begin
        $display("%0t: base_address expected %h actual %h", $time, e.base, base);
        errors++;
      end
      if (rbyte !== e.rbyte) begin
        $display("%0t: read_byte expected %h actual %h", $time, e.rbyte, rbyte);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_we;
  logic [19:0] cfg_wdata;

  pager_model model = new();
  int send_gap_pct;
  int stall_pct;
  int quiet;
  int rg_pid[$];
  int rg_base[$];
  int rg_len[$];

  paged_allocator_with_translation_unit u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      model.check_result(m_axis_tuser[0], m_axis_tdata[19:0], m_axis_tdata[27:20]);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_word(bit [1:0] mode, bit [3:0] pid, bit [20:0] size,
                           bit [19:0] addr, bit [7:0] wbyte);
    result_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {3'b000, wbyte, addr, size, pid};
    do @(posedge clk); while (!s_axis_tready);
    r = model.take_request(mode, pid, size, addr, wbyte);
    // remember live regions so later requests hit mapped pages
    if (mode == MODE_ALLOC && r.status == 1'b0 && size != 0) begin
      rg_pid.push_back(pid);
      rg_base.push_back(r.base);
      rg_len.push_back(size);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (model.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_start(int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= 20'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
    model.load_start(value);
  endtask

  task automatic random_item();
    int r, i, a;
    r = $urandom_range(99);
    if (r < 5 || rg_pid.size() == 0 && r >= 45) begin
      send_word(2'($urandom_range(3)), 4'($urandom_range(15)),
                21'($urandom_range(1048576)), 20'($urandom), 8'($urandom));
    end else if (r < 25) begin
      send_word(MODE_ALLOC, 4'($urandom_range(1, 8)),
                21'(($urandom_range(9) == 0) ? $urandom_range(65536) : $urandom_range(6000)),
                20'($urandom), 8'($urandom));
    end else if (r < 45) begin
      if (rg_pid.size() == 0) begin
        send_word(MODE_FREE, 4'($urandom_range(1, 8)), 21'($urandom), 20'($urandom),
                  8'($urandom));
      end else begin
        i = $urandom_range(rg_pid.size() - 1);
        a = rg_base[i] + (($urandom_range(3) == 0) ? $urandom_range(rg_len[i] - 1) : 0);
        send_word(MODE_FREE, 4'(rg_pid[i]), 21'($urandom), 20'(a), 8'($urandom));
        rg_pid.delete(i);
        rg_base.delete(i);
        rg_len.delete(i);
      end
    end else begin
      i = $urandom_range(rg_pid.size() - 1);
      a = rg_base[i] + $urandom_range(rg_len[i] - 1);
      send_word(($urandom_range(1) == 0) ? MODE_WRITE : MODE_READ, 4'(rg_pid[i]),
                21'($urandom), 20'(a), 8'($urandom));
    end
  endtask

  initial begin
    int starts[5];
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    send_gap_pct  = 0;
    stall_pct     = 0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: edges of every field, bad pids, limits, partial free
    send_word(MODE_READ,  1, 0, 20'h00000, 8'h00);
    send_word(MODE_ALLOC, 1, 0, 20'hFFFFF, 8'hFF);
    send_word(MODE_ALLOC, 1, 1, 0, 0);
    send_word(MODE_WRITE, 1, 0, 20'd1024, 8'hA5);
    send_word(MODE_READ,  1, 0, 20'd1024, 8'h00);
    send_word(MODE_READ,  1, 0, 20'd1025, 8'h00);
    send_word(MODE_WRITE, 8, 0, 20'hFFFFF, 8'hFF);
    send_word(MODE_ALLOC, 0, 5000, 0, 0);
    send_word(MODE_ALLOC, 15, 5000, 0, 0);
    send_word(MODE_READ,  9, 0, 20'd1024, 0);
    send_word(MODE_ALLOC, 2, 21'd1048576, 0, 0);
    send_word(MODE_ALLOC, 3, 3000, 0, 0);
    send_word(MODE_WRITE, 3, 0, 20'd4023, 8'hFF);
    send_word(MODE_READ,  3, 0, 20'd4023, 0);
    send_word(MODE_FREE,  3, 0, 20'd2048, 0);
    send_word(MODE_READ,  3, 0, 20'd1024, 0);
    send_word(MODE_FREE,  3, 0, 20'd3072, 0);
    send_word(MODE_ALLOC, 4, 250 * 1024, 0, 0);
    send_word(MODE_ALLOC, 5, 20 * 1024, 0, 0);
    send_word(MODE_FREE,  4, 0, 20'd1024, 0);
    send_word(MODE_ALLOC, 8, 1, 0, 8'h5A);
    send_word(MODE_FREE,  8, 0, 20'd1024, 0);
    send_word(MODE_FREE,  8, 0, 20'd1024, 0);

    starts[0] = 1024;
    starts[1] = 0;
    starts[2] = 20'hFFFFF;
    starts[3] = $urandom_range(1, 300000) | 1;
    starts[4] = 1024 + $urandom_range(1, 1023);
    for (int p = 0; p < 5; p++) begin
      drain();
      write_start(starts[p]);
      case (p % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 78; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 78; end
        default: begin send_gap_pct = 14; stall_pct = 14; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) random_item();
    end

    drain();
    stall_pct = 0;
    repeat (50) @(posedge clk);
    if (model.errors == 0 && model.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/pat_pkg.sv
hw/rtl/pat_ram.sv
hw/rtl/paged_allocator_with_translation_unit.sv
verif/testbench.sv
